// ----- rtl/ipu_pkg.sv -----
`default_nettype none

package ipu_pkg;

    // Configuration register indexes
    localparam logic [1:0] CFG_SCALE  = 2'd0;
    localparam logic [1:0] CFG_WIDTH  = 2'd1;
    localparam logic [1:0] CFG_HEIGHT = 2'd2;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Item function codes
    localparam logic FUNC_PIXEL = 1'b0;
    localparam logic FUNC_TICK  = 1'b1;

    localparam int         SCALE_W   = 7;
    localparam int         SRC_W_W   = 13;
    localparam int         SRC_H_W   = 16;
    localparam int         PIX_W     = 24;
    localparam logic [6:0] SCALE_MAX = 7'd100;

    // One run on its way to the output register
    typedef struct packed {
        logic [PIX_W-1:0]   pix;
        logic [SCALE_W-1:0] repeat_count;
        logic [1:0]         pad_bytes;
        logic               row_end;
        logic               frame_end;
        logic               overrun;
    } ipu_run_t;

endpackage

`default_nettype wire

// ----- rtl/ipu_ram.sv -----
`default_nettype none

module ipu_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 4096
) (
    input  wire logic                                  clk,
    input  wire logic                                  we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                      wdata,
    input  wire logic                                  re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        // hold the last word when no read is issued
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- rtl/integer_pixel_upscaler.sv -----
`default_nettype none

// Nearest-neighbor integer upscaler for rows of 24-bit pixels.
// Source channel (src_valid / src_stall): func selects a source pixel or a
// replay tick. Each pixel is written to the line buffer and answered with
// one run that repeats it repeat_count times. The run that ends a row
// carries row_end and pad_bytes (output row width mod 4). After a row,
// scale-1 passes of ticks replay the stored row, one run per tick; the
// run that ends the last pass carries frame_end on the last source row.
// A pixel during replay is dropped and answered with overrun set; a tick
// outside replay gives no run.
// Result channel (res_valid / res_stall): one run per word.
// A run passes through stage 1 (line buffer read) and then the output
// register. Throughput: one item per cycle while src_stall is low; the
// line buffer has a separate write and read port and a pixel write never
// meets a tick read, so items issue back to back.
// A stalled receiver fills the output register and the stage before it,
// then src_stall rises. Reset clears counters and the pipeline and sets
// the registers (cfg_valid / cfg_ready, always ready) to 1; the line
// buffer is not cleared.
module integer_pixel_upscaler #(
    parameter int MAX_WIDTH = 4096
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [ipu_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [ipu_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                           src_valid,
    output logic                                src_stall,
    input  wire logic                           func,
    input  wire logic [7:0]                     blue_in,
    input  wire logic [7:0]                     green_in,
    input  wire logic [7:0]                     red_in,
    output logic                                res_valid,
    input  wire logic                           res_stall,
    output logic [7:0]                          blue_out,
    output logic [7:0]                          green_out,
    output logic [7:0]                          red_out,
    output logic [ipu_pkg::SCALE_W-1:0]         repeat_count,
    output logic [1:0]                          pad_bytes,
    output logic                                row_end,
    output logic                                frame_end,
    output logic                                overrun
);

    import ipu_pkg::*;

    localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WW    = ($clog2(MAX_WIDTH + 1) > SRC_W_W) ? $clog2(MAX_WIDTH + 1) : SRC_W_W;

    logic [SCALE_W-1:0] scale_reg;
    logic [SRC_W_W-1:0] width_reg;
    logic [SRC_H_W-1:0] height_reg;

    logic [COL_W-1:0]   col_reg, col_next;
    logic [SRC_H_W-1:0] row_reg, row_next;
    logic [SCALE_W-1:0] pass_reg, pass_next;
    logic               active_reg, active_next;

    logic               s1_valid_reg, s1_valid_next;
    ipu_run_t           s1_run_reg, s1_run_next;
    logic               s1_ram_reg, s1_ram_next;
    ipu_run_t           s1_out;

    logic               out_valid_reg;
    ipu_run_t           out_run_reg;

    logic               acc, out_free, s1_move;
    logic [SCALE_W-1:0] eff_s;
    logic [WW-1:0]      width_ext, eff_w;
    logic               at_end, last_row;
    logic [SCALE_W-1:0] pass_inc;
    logic [PIX_W-1:0]   pix_in, ram_rdata;
    logic               ram_we, ram_re;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg  <= SCALE_W'(1);
            width_reg  <= SRC_W_W'(1);
            height_reg <= SRC_H_W'(1);
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_SCALE:  scale_reg  <= cfg_data[SCALE_W-1:0];
                CFG_WIDTH:  width_reg  <= cfg_data[SRC_W_W-1:0];
                CFG_HEIGHT: height_reg <= cfg_data;
                default:    ;
            endcase
        end
    end

    // Effective settings
    always_comb
    begin
        if (scale_reg == '0)
            eff_s = SCALE_W'(1);
        else if (scale_reg > SCALE_MAX)
            eff_s = SCALE_MAX;
        else
            eff_s = scale_reg;

        width_ext = WW'(width_reg);
        if (width_ext == '0)
            eff_w = WW'(1);
        else if (width_ext > WW'(MAX_WIDTH))
            eff_w = WW'(MAX_WIDTH);
        else
            eff_w = width_ext;
    end

    assign at_end   = (WW'(col_reg) + WW'(1)) >= eff_w;
    assign last_row = ({1'b0, row_reg} + 17'd1)
                      >= {1'b0, (height_reg == '0) ? SRC_H_W'(1) : height_reg};
    assign pass_inc = pass_reg + SCALE_W'(1);
    assign pix_in   = {red_in, green_in, blue_in};

    // Pipeline flow: output register frees, stage 1 moves, source advances
    assign out_free  = !out_valid_reg || !res_stall;
    assign s1_move   = s1_valid_reg && out_free;
    assign src_stall = s1_valid_reg && !out_free;
    assign acc       = src_valid && !src_stall;

    always_comb
    begin
        col_next      = col_reg;
        row_next      = row_reg;
        pass_next     = pass_reg;
        active_next   = active_reg;
        s1_valid_next = s1_move ? 1'b0 : s1_valid_reg;
        s1_run_next   = s1_run_reg;
        s1_ram_next   = s1_ram_reg;
        ram_we        = 1'b0;
        ram_re        = 1'b0;

        if (acc)
        begin
            s1_run_next              = '0;
            s1_ram_next              = 1'b0;
            s1_run_next.repeat_count = eff_s;
            if (func == FUNC_PIXEL)
            begin
                s1_valid_next = 1'b1;
                if (active_reg)
                begin
                    // drop the pixel, flag it
                    s1_run_next         = '0;
                    s1_run_next.overrun = 1'b1;
                end
                else
                begin
                    ram_we          = 1'b1;
                    s1_run_next.pix = pix_in;
                    if (at_end)
                    begin
                        s1_run_next.pad_bytes = 2'(eff_w[1:0] * eff_s[1:0]);
                        s1_run_next.row_end   = 1'b1;
                        col_next              = '0;
                        if (eff_s == SCALE_W'(1))
                        begin
                            s1_run_next.frame_end = last_row;
                            row_next              = last_row ? '0 : row_reg + SRC_H_W'(1);
                        end
                        else
                        begin
                            active_next = 1'b1;
                            pass_next   = SCALE_W'(1);
                        end
                    end
                    else
                    begin
                        col_next = col_reg + COL_W'(1);
                    end
                end
            end
            else if (active_reg)
            begin
                s1_valid_next = 1'b1;
                s1_ram_next   = 1'b1;
                ram_re        = 1'b1;
                if (at_end)
                begin
                    s1_run_next.pad_bytes = 2'(eff_w[1:0] * eff_s[1:0]);
                    s1_run_next.row_end   = 1'b1;
                    col_next              = '0;
                    pass_next             = pass_inc;
                    if (pass_inc >= eff_s || pass_inc == '0)
                    begin
                        active_next           = 1'b0;
                        pass_next             = '0;
                        s1_run_next.frame_end = last_row;
                        row_next              = last_row ? '0 : row_reg + SRC_H_W'(1);
                    end
                end
                else
                begin
                    col_next = col_reg + COL_W'(1);
                end
            end
        end
    end

    // replay runs take their pixel from the line buffer read
    always_comb
    begin
        s1_out = s1_run_reg;
        if (s1_ram_reg)
        begin
            s1_out.pix = ram_rdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            row_reg       <= '0;
            pass_reg      <= '0;
            active_reg    <= 1'b0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            pass_reg     <= pass_next;
            active_reg   <= active_next;
            s1_valid_reg <= s1_valid_next;
            if (out_free)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        s1_run_reg <= s1_run_next;
        s1_ram_reg <= s1_ram_next;
        if (s1_move)
        begin
            out_run_reg <= s1_out;
        end
    end

    ipu_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (col_reg),
        .wdata (pix_in),
        .re    (ram_re),
        .raddr (col_reg),
        .rdata (ram_rdata)
    );

    assign res_valid    = out_valid_reg;
    assign blue_out     = out_run_reg.pix[7:0];
    assign green_out    = out_run_reg.pix[15:8];
    assign red_out      = out_run_reg.pix[23:16];
    assign repeat_count = out_run_reg.repeat_count;
    assign pad_bytes    = out_run_reg.pad_bytes;
    assign row_end      = out_run_reg.row_end;
    assign frame_end    = out_run_reg.frame_end;
    assign overrun      = out_run_reg.overrun;

endmodule

`default_nettype wire

// ----- rtl/ipu_checker.sv -----
`default_nettype none

module ipu_checker (
    input wire logic                   clk,
    input wire logic                   rst_n,
    input wire logic                   res_valid,
    input wire logic                   res_stall,
    input wire logic [7:0]             blue_out,
    input wire logic [ipu_pkg::SCALE_W-1:0] repeat_count,
    input wire logic [1:0]             pad_bytes,
    input wire logic                   row_end,
    input wire logic                   frame_end,
    input wire logic                   overrun
);

    import ipu_pkg::*;

    // a dropped pixel carries no run
    a_overrun_empty: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && overrun |-> repeat_count == '0 && !row_end && !frame_end)
        else $error("overrun word carries run data");

    a_repeat_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !overrun |-> repeat_count != '0 && repeat_count <= SCALE_MAX)
        else $error("repeat_count out of range");

    a_frame_row: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && frame_end |-> row_end)
        else $error("frame_end without row_end");

    a_pad_row: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && pad_bytes != 2'd0 |-> row_end)
        else $error("pad bytes before row end");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(blue_out) && $stable(repeat_count))
        else $error("stalled word changed");

endmodule

bind integer_pixel_upscaler ipu_checker u_ipu_checker (.*);

`default_nettype wire
